### src/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, muted while reset is asserted.
`define ADGL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Concurrent check that also runs during reset.
`define ADGL_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/adgl_pkg.sv
// Package for the averaged deadband gain loop: widths, reset values,
// register indexes and the constant-divide helper values. No dependencies.
`timescale 1ns / 1ps

package adgl_pkg;

    // Sample ring depth.
    localparam int WINDOW = 50;

    localparam int SAMPLE_W = 10;
    localparam int CODE_W   = 12;
    localparam int THR_W    = 10;
    localparam int AVG_W    = 10;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // Running sum of the full ring never exceeds WINDOW * SAMPLE_MAX.
    localparam int SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);

    // Divide by WINDOW as multiply by a rounded-up reciprocal and shift;
    // exact for every sum below 2**SUM_W.
    localparam int DIV_SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int DIV_MULT_W = DIV_SHIFT + 1;
    localparam longint DIV_MULT_INT = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(DIV_MULT_INT);
    localparam int PROD_W = SUM_W + DIV_MULT_W;

    localparam logic [CODE_W-1:0] CODE_MAX        = CODE_W'(4095);
    localparam logic [CODE_W-1:0] CODE_MIN        = CODE_W'(1);
    localparam logic [CODE_W-1:0] LOOP_CODE_RESET = CODE_W'(2047);

    localparam logic [THR_W-1:0]  HIGH_THR_RESET   = THR_W'(80);
    localparam logic [THR_W-1:0]  LOW_THR_RESET    = THR_W'(55);
    localparam logic [CODE_W-1:0] STEP_SIZE_RESET  = CODE_W'(20);
    localparam logic [CODE_W-1:0] FIXED_CODE_RESET = CODE_W'(2000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_THR   = 2'd0,
        CFG_LOW_THR    = 2'd1,
        CFG_STEP_SIZE  = 2'd2,
        CFG_FIXED_CODE = 2'd3
    } t_cfg_idx;

endpackage

### src/adgl_in_if.sv
// Input channel of the gain loop: valid/ready plus one input word.
// Depends on adgl_pkg for field widths.
`timescale 1ns / 1ps

interface adgl_in_if import adgl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
    logic                key_down;

    modport source (output valid, output mode, output sample, output key_down, input ready);
    modport sink   (input valid, input mode, input sample, input key_down, output ready);
endinterface

### src/adgl_out_if.sv
// Result channel of the gain loop: valid/ready plus one result word.
// Depends on adgl_pkg for field widths.
`timescale 1ns / 1ps

interface adgl_out_if import adgl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] dac_code;
    logic              gain_state;
    logic [AVG_W-1:0]  window_average;

    modport source (output valid, output dac_code, output gain_state, output window_average,
                    input ready);
    modport sink   (input valid, input dac_code, input gain_state, input window_average,
                    output ready);
endinterface

### src/averaged_deadband_gain_loop.sv
// Averaged deadband gain loop. Throughput: one word per cycle on the input
// while nothing downstream stalls. A sample word updates the ring and running
// sum in the cycle after it is accepted; a control word reaches the output
// register through the divide stage (A), then the code-update stage (B).
// Reset: synchronous, active low; the ring reads as zero until the write
// pointer first wraps (fill flag), so no clearing pass is needed.
`timescale 1ns / 1ps

module averaged_deadband_gain_loop import adgl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    adgl_in_if.sink              i_in,
    adgl_out_if.source           o_out
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  r_high_thr;
    logic [THR_W-1:0]  r_low_thr;
    logic [CODE_W-1:0] r_step_size;
    logic [CODE_W-1:0] r_fixed_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr   <= HIGH_THR_RESET;
            r_low_thr    <= LOW_THR_RESET;
            r_step_size  <= STEP_SIZE_RESET;
            r_fixed_code <= FIXED_CODE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_HIGH_THR:   r_high_thr   <= i_cfg_wdata[THR_W-1:0];
                CFG_LOW_THR:    r_low_thr    <= i_cfg_wdata[THR_W-1:0];
                CFG_STEP_SIZE:  r_step_size  <= i_cfg_wdata[CODE_W-1:0];
                CFG_FIXED_CODE: r_fixed_code <= i_cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    //   A: input register. Samples retire here (ring write, sum update);
    //      control words form the average and move on to B.
    //   B: key edge, deadband update of the loop code, result to output.
    //   Output register: holds a result until the sink takes it.
    // ------------------------------------------------------------------
    logic r_a_vld, r_b_vld, r_o_vld;
    logic r_a_mode;
    logic out_free, b_free, a_done, a_free;
    logic in_acc, a_smp_wr, a_to_b, b_to_o;

    assign out_free = !r_o_vld || o_out.ready;
    assign b_free   = !r_b_vld || out_free;
    // A sample word always finishes in A; a control word waits for B.
    assign a_done   = !r_a_mode || b_free;
    assign a_free   = !r_a_vld || a_done;

    assign i_in.ready = a_free;
    assign in_acc     = i_in.valid && a_free;
    assign a_smp_wr   = r_a_vld && !r_a_mode;
    assign a_to_b     = r_a_vld && r_a_mode && b_free;
    assign b_to_o     = r_b_vld && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_vld <= 1'b1;
            end else if (a_done) begin
                r_a_vld <= 1'b0;
            end
            if (a_to_b) begin
                r_b_vld <= 1'b1;
            end else if (b_to_o) begin
                r_b_vld <= 1'b0;
            end
            if (b_to_o) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring write pointer and fill flag
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] n_wr_idx;
    logic             r_full;
    logic             ptr_wrap;

    assign ptr_wrap = (r_wr_idx == IDX_W'(WINDOW - 1));
    assign n_wr_idx = ptr_wrap ? '0 : r_wr_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_full   <= 1'b0;
        end else if (in_acc && !i_in.mode) begin
            // Advance at accept so the next sample reads its own slot.
            r_wr_idx <= n_wr_idx;
            if (ptr_wrap) begin
                r_full <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A payload
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_a_sample;
    logic                r_a_key;
    logic [IDX_W-1:0]    r_a_idx;
    logic                r_a_old_ok;   // slot held a written value
    logic                r_a_byp;      // slot was written on the accept edge
    logic [SAMPLE_W-1:0] r_a_byp_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_mode <= 1'b0;
        end else if (in_acc) begin
            r_a_mode <= i_in.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_sample   <= i_in.sample;
            r_a_key      <= i_in.key_down;
            r_a_idx      <= r_wr_idx;
            r_a_old_ok   <= r_full;
            // Only a one-entry ring reads the slot that A is writing.
            r_a_byp      <= a_smp_wr && (r_a_idx == r_wr_idx);
            r_a_byp_data <= r_a_sample;
        end
    end

    // Sample ring
    logic [SAMPLE_W-1:0] ram_q;

    adgl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (a_smp_wr),
        .i_waddr (r_a_idx),
        .i_wdata (r_a_sample),
        .i_re    (in_acc && !i_in.mode),
        .i_raddr (r_wr_idx),
        .o_rdata (ram_q)
    );

    // Running sum: drop the leaving sample, add the new one.
    logic [SAMPLE_W-1:0] a_old;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;

    always_comb begin
        if (r_a_byp) begin
            a_old = r_a_byp_data;
        end else if (r_a_old_ok) begin
            a_old = ram_q;
        end else begin
            a_old = '0;
        end
        n_sum = r_sum - SUM_W'(a_old) + SUM_W'(r_a_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (a_smp_wr) begin
            r_sum <= n_sum;
        end
    end

    // Average by reciprocal multiply; the sum holds still while a control
    // word sits in A because nothing behind it can retire.
    logic [PROD_W-1:0] a_prod;
    logic [AVG_W-1:0]  a_avg;

    assign a_prod = PROD_W'(r_sum) * PROD_W'(DIV_MULT);
    assign a_avg  = a_prod[DIV_SHIFT +: AVG_W];

    // ------------------------------------------------------------------
    // Stage B: key edge and deadband code update
    // ------------------------------------------------------------------
    logic [AVG_W-1:0] r_b_avg;
    logic             r_b_key;

    always_ff @(posedge i_clk) begin
        if (a_to_b) begin
            r_b_avg <= a_avg;
            r_b_key <= r_a_key;
        end
    end

    logic [CODE_W-1:0] r_loop_code;
    logic              r_fixed_sel;
    logic              r_key_was;
    logic [CODE_W-1:0] n_loop_code;
    logic              n_fixed_sel;
    logic [CODE_W-1:0] b_lowered;
    logic [CODE_W:0]   b_raise_sum;

    always_comb begin
        // Toggle only on a press edge.
        n_fixed_sel = r_fixed_sel ^ (r_b_key && !r_key_was);

        // Lower first, floored at the minimum code.
        if (r_b_avg > r_high_thr) begin
            b_lowered = (r_loop_code > r_step_size) ? r_loop_code - r_step_size : CODE_MIN;
        end else begin
            b_lowered = r_loop_code;
        end

        // Then raise, capped at the maximum code.
        b_raise_sum = {1'b0, b_lowered} + {1'b0, r_step_size};
        if (r_b_avg < r_low_thr) begin
            n_loop_code = (b_raise_sum >= {1'b0, CODE_MAX}) ? CODE_MAX
                                                            : b_raise_sum[CODE_W-1:0];
        end else begin
            n_loop_code = b_lowered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_code <= LOOP_CODE_RESET;
            r_fixed_sel <= 1'b0;
            r_key_was   <= 1'b0;
        end else if (b_to_o) begin
            r_loop_code <= n_loop_code;
            r_fixed_sel <= n_fixed_sel;
            r_key_was   <= r_b_key;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] r_o_code;
    logic              r_o_gain;
    logic [AVG_W-1:0]  r_o_avg;

    always_ff @(posedge i_clk) begin
        if (b_to_o) begin
            r_o_code <= n_fixed_sel ? r_fixed_code : n_loop_code;
            r_o_gain <= n_fixed_sel;
            r_o_avg  <= r_b_avg;
        end
    end

    assign o_out.valid          = r_o_vld;
    assign o_out.dac_code       = r_o_code;
    assign o_out.gain_state     = r_o_gain;
    assign o_out.window_average = r_o_avg;

endmodule

### src/adgl_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`timescale 1ns / 1ps

module adgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/adgl_checker.sv
// Port-level checks for the averaged deadband gain loop, bound to the top.
// Depends on assert_macros.svh and adgl_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adgl_checker import adgl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CODE_W-1:0] i_out_dac_code,
    input logic              i_out_gain_state,
    input logic [AVG_W-1:0]  i_out_window_average
);

    // A stalled result holds.
    `ADGL_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_dac_code) && $stable(i_out_gain_state) && $stable(i_out_window_average), "stalled result changed")

    // With room at the output the pipeline drains, so input is open.
    `ADGL_ASSERT(a_in_open, i_clk, i_rst_n, !i_out_valid || i_out_ready |-> i_in_ready, "input blocked with free output")

    // The loop code is floored at one and never reads zero.
    `ADGL_ASSERT(a_code_nonzero, i_clk, i_rst_n, i_out_valid && !i_out_gain_state |-> i_out_dac_code != '0, "loop code reached zero")

    // Reset empties the output register.
    `ADGL_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind averaged_deadband_gain_loop adgl_checker u_adgl_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_dac_code       (o_out.dac_code),
    .i_out_gain_state     (o_out.gain_state),
    .i_out_window_average (o_out.window_average)
);
